/* rtl/box_filter_image_downscale_macros.svh */
// ----------------------------------------------------------------------------
// Box filter downscale assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_IMAGE_DOWNSCALE_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALE_MACROS_SVH

// same-cycle implication
`define BFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bfd_pkg.sv */
// ----------------------------------------------------------------------------
// Box filter downscale package
// Widths, types, register codes and the reciprocal table for the divider.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int NCH      = 3;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = 14;
  localparam int SUMS_W   = NCH * SUM_W;
  localparam int FACTOR_W = 4;
  localparam int LW_W     = 11;
  localparam int RECIP_W  = 18;
  localparam int RECIP_SH = 17;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 4'd8;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 4'd2;
  localparam logic [LW_W-1:0]     LW_RST     = 11'd320;

  typedef logic [PIX_W-1:0]              pix_t;
  typedef logic [SUM_W-1:0]              sum_t;
  typedef logic [NCH-1:0][PIX_W-1:0]     pixs_t;
  typedef logic [NCH-1:0][SUM_W-1:0]     sums_t;
  typedef logic [RECIP_W-1:0]            recip_t;
  typedef logic [FACTOR_W-1:0]           factor_t;
  typedef logic [LW_W-1:0]               lw_t;

  typedef enum logic {
    REG_FACTOR     = 1'b0,
    REG_LINE_WIDTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic active;
    logic first;
    logic emit;
    logic row_end;
  } pos_ctl_t;

  // ceil(2^17 / f); exact floor division for dividends below 2^14
  function automatic recip_t recip_f(input factor_t f);
    recip_t r;
    unique case (f)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

/* rtl/bfd_sum_mem.sv */
// ----------------------------------------------------------------------------
// Column sum memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfd_sum_mem
  import bfd_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sums_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output sums_t         rdata
);

  sums_t mem [DEPTH];
  sums_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bfd_pos.sv */
// ----------------------------------------------------------------------------
// Position tracker
// Raster position counters, block geometry from the registers, and the
// per-item control flags and sum address.
// ----------------------------------------------------------------------------
module bfd_pos
  import bfd_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int AW             = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  factor_t       cfg_factor,
  input  lw_t           cfg_line_width,
  input  logic          step,
  input  logic          frame_start,
  output factor_t       f_eff,
  output logic [AW-1:0] addr,
  output pos_ctl_t      ctl
);

  localparam int CW = AW + 1;
  localparam int MW = (CW > LW_W) ? CW : LW_W;

  logic [CW-1:0] lw_eff;
  logic [MW-1:0] lw_ext;
  logic [CW+RECIP_W-1:0] bl_prod;
  logic [CW+FACTOR_W-1:0] bf_prod;

  logic [CW-1:0] bl_r, bf_r;
  logic [AW-1:0] ic_r, oc_r, ic_nxt, oc_nxt;
  logic [2:0]    rib_r, cib_r, rib_nxt, cib_nxt;

  logic [AW-1:0] ic0, oc0, ic1, oc1, oc3;
  logic [2:0]    rib0, cib0, cib1, rib2, cib2, cib3;
  logic [3:0]    rib1, cib_inc, rib_inc;
  logic [CW-1:0] ic_inc;
  logic          row_wrap;

  always_comb begin
    priority if (cfg_factor == '0) begin
      f_eff = 4'd1;
    end else if (cfg_factor > FACTOR_MAX) begin
      f_eff = FACTOR_MAX;
    end else begin
      f_eff = cfg_factor;
    end
  end

  always_comb begin
    lw_ext = MW'(cfg_line_width);
    priority if (cfg_line_width == '0) begin
      lw_eff = CW'(1);
    end else if (lw_ext > MW'(MAX_LINE_WIDTH)) begin
      lw_eff = CW'(MAX_LINE_WIDTH);
    end else begin
      lw_eff = CW'(cfg_line_width);
    end
  end

  assign bl_prod = (CW+RECIP_W)'(lw_eff) * (CW+RECIP_W)'(recip_f(f_eff));
  assign bf_prod = (CW+FACTOR_W)'(bl_r) * (CW+FACTOR_W)'(f_eff);

  // block count and covered width, registered in turn: bl_r, then bf_r from bl_r
  always_ff @(posedge clk) begin
    bl_r <= CW'(bl_prod >> RECIP_SH);
    bf_r <= CW'(bf_prod);
  end

  always_comb begin
    ic0  = frame_start ? '0 : ic_r;
    oc0  = frame_start ? '0 : oc_r;
    rib0 = frame_start ? '0 : rib_r;
    cib0 = frame_start ? '0 : cib_r;

    row_wrap = {1'b0, ic0} >= lw_eff;
    ic1  = row_wrap ? '0 : ic0;
    oc1  = row_wrap ? '0 : oc0;
    cib1 = row_wrap ? '0 : cib0;
    rib1 = row_wrap ? {1'b0, rib0} + 4'd1 : {1'b0, rib0};

    rib2 = (rib1 >= f_eff) ? '0 : rib1[2:0];
    cib2 = ({1'b0, cib1} >= f_eff) ? '0 : cib1;

    ctl.active  = ({1'b0, ic1} < bf_r) && ({1'b0, oc1} < bl_r);
    ctl.first   = (rib2 == '0) && (cib2 == '0);
    ctl.emit    = ({1'b0, rib2} == f_eff - 4'd1) && ({1'b0, cib2} == f_eff - 4'd1);
    ctl.row_end = ({1'b0, oc1} + CW'(1)) == bl_r;
    addr        = oc1;

    cib_inc = {1'b0, cib2} + 4'd1;
    cib3    = cib2;
    oc3     = oc1;
    if (ctl.active) begin
      if (cib_inc >= f_eff) begin
        cib3 = '0;
        oc3  = oc1 + AW'(1);
      end else begin
        cib3 = cib_inc[2:0];
      end
    end

    ic_inc  = {1'b0, ic1} + CW'(1);
    rib_inc = {1'b0, rib2} + 4'd1;
    if (ic_inc >= lw_eff) begin
      ic_nxt  = '0;
      oc_nxt  = '0;
      cib_nxt = '0;
      rib_nxt = (rib_inc >= f_eff) ? '0 : rib_inc[2:0];
    end else begin
      ic_nxt  = ic_inc[AW-1:0];
      oc_nxt  = oc3;
      cib_nxt = cib3;
      rib_nxt = rib2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r  <= '0;
      oc_r  <= '0;
      rib_r <= '0;
      cib_r <= '0;
    end else if (step) begin
      ic_r  <= ic_nxt;
      oc_r  <= oc_nxt;
      rib_r <= rib_nxt;
      cib_r <= cib_nxt;
    end
  end

endmodule

/* rtl/bfd_div.sv */
// ----------------------------------------------------------------------------
// Block average divider
// Divides three channel sums by factor squared as two reciprocal
// multiplications by 1/factor, with the result held in the output register.
// ----------------------------------------------------------------------------
module bfd_div
  import bfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  factor_t f_eff,
  input  logic    i_valid,
  output logic    i_ready,
  input  sums_t   i_sums,
  input  logic    i_row_end,
  output logic    o_valid,
  input  logic    o_stall,
  output pixs_t   o_pix,
  output logic    o_row_end
);

  localparam int PW = SUM_W + RECIP_W;

  logic   s1_v_r, s2_v_r, o_v_r;
  sums_t  s1_sum_r, s2_q_r;
  logic   s1_rend_r, s2_rend_r, o_rend_r;
  pixs_t  o_pix_r;

  logic   o_free, s2_free, s1_free;
  recip_t recip;
  logic [PW-1:0] p1 [NCH];
  logic [PW-1:0] p2 [NCH];
  sums_t  q1;
  pixs_t  q2;

  assign o_free  = !o_v_r || !o_stall;
  assign s2_free = !s2_v_r || o_free;
  assign s1_free = !s1_v_r || s2_free;
  assign i_ready = s1_free;
  assign recip   = recip_f(f_eff);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      p1[c] = PW'(s1_sum_r[c]) * PW'(recip);
      p2[c] = PW'(s2_q_r[c]) * PW'(recip);
      q1[c] = SUM_W'(p1[c] >> RECIP_SH);
      q2[c] = PIX_W'(p2[c] >> RECIP_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= i_valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (o_free) begin
        o_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (i_valid && s1_free) begin
      s1_sum_r  <= i_sums;
      s1_rend_r <= i_row_end;
    end
    if (s1_v_r && s2_free) begin
      s2_q_r    <= q1;
      s2_rend_r <= s1_rend_r;
    end
    if (s2_v_r && o_free) begin
      o_pix_r  <= q2;
      o_rend_r <= s2_rend_r;
    end
  end

  assign o_valid   = o_v_r;
  assign o_pix     = o_pix_r;
  assign o_row_end = o_rend_r;

endmodule

/* rtl/box_filter_image_downscale.sv */
// ----------------------------------------------------------------------------
// Box filter image downscale
// RGB888 raster downscaler: averages square blocks of factor x factor pixels
// and emits one pixel per block, using one running sum per output column.
// ----------------------------------------------------------------------------
// channel  handshake            fields
// in       in_valid/in_stall    in_red_in, in_green_in, in_blue_in, in_frame_start
// out      out_valid/out_stall  out_red_out, out_green_out, out_blue_out, out_row_end
// cfg      APB psel/penable     factor at 0x0, line_width at 0x4
//
// One item per cycle unless in_stall: a read of the column sum memory at accept,
// add and write back in the accumulate stage; a write followed by a read of the
// same entry is forwarded. Reset sets register defaults and clears positions
// and valid flags, not sums; input stalls after reset and after each register
// write while the block geometry settles. An output stall fills the three
// divider registers, then holds the accumulate stage once it holds a block result.
// ----------------------------------------------------------------------------
`include "box_filter_image_downscale_macros.svh"

module box_filter_image_downscale
  import bfd_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_row_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam logic [1:0] SETTLE_CYC = 2'd2;

  factor_t    factor_r;
  lw_t        lw_r;
  logic [1:0] settle_r;
  logic       cfg_we;
  reg_idx_t   reg_idx;

  factor_t       f_eff;
  logic [AW-1:0] pos_addr;
  pos_ctl_t      pos_ctl;
  logic          in_acc;

  logic          b_v_r, fw_r;
  pixs_t         b_pix_r;
  pos_ctl_t      b_ctl_r;
  logic [AW-1:0] b_addr_r;
  sums_t         fw_data_r;
  sums_t         mem_rdata, b_old, b_sum;
  logic          b_emit, b_done, fw_hit, mem_we;
  logic          div_rdy;
  pixs_t         div_pix;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_FACTOR:     prdata = 32'(factor_r);
      REG_LINE_WIDTH: prdata = 32'(lw_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      lw_r     <= LW_RST;
      settle_r <= SETTLE_CYC;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx)
          REG_FACTOR:     factor_r <= pwdata[FACTOR_W-1:0];
          REG_LINE_WIDTH: lw_r     <= pwdata[LW_W-1:0];
        endcase
      end
      if (cfg_we) begin
        settle_r <= SETTLE_CYC;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // position tracking
  bfd_pos #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .AW             (AW)
  ) u_pos (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_factor     (factor_r),
    .cfg_line_width (lw_r),
    .step           (in_acc),
    .frame_start    (in_frame_start),
    .f_eff          (f_eff),
    .addr           (pos_addr),
    .ctl            (pos_ctl)
  );

  // accumulate stage
  assign b_emit   = b_ctl_r.active && b_ctl_r.emit;
  assign b_done   = b_v_r && (!b_emit || div_rdy);
  assign in_stall = (settle_r != '0) || (b_v_r && !b_done);
  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = b_done && b_ctl_r.active;
  assign fw_hit   = in_acc && mem_we && pos_ctl.active && (pos_addr == b_addr_r);
  assign b_old    = fw_r ? fw_data_r : mem_rdata;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      b_sum[c] = b_ctl_r.first ? SUM_W'(b_pix_r[c])
                               : b_old[c] + SUM_W'(b_pix_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      fw_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        b_v_r <= 1'b1;
        fw_r  <= fw_hit;
      end else if (b_done) begin
        b_v_r <= 1'b0;
        fw_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pix_r  <= {in_blue_in, in_green_in, in_red_in};
      b_ctl_r  <= pos_ctl;
      b_addr_r <= pos_addr;
    end
    if (fw_hit) begin
      fw_data_r <= b_sum;
    end
  end

  bfd_sum_mem #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (b_addr_r),
    .wdata (b_sum),
    .re    (in_acc),
    .raddr (pos_addr),
    .rdata (mem_rdata)
  );

  // averaging
  bfd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .f_eff     (f_eff),
    .i_valid   (b_v_r && b_emit),
    .i_ready   (div_rdy),
    .i_sums    (b_sum),
    .i_row_end (b_ctl_r.row_end),
    .o_valid   (out_valid),
    .o_stall   (out_stall),
    .o_pix     (div_pix),
    .o_row_end (out_row_end)
  );

  assign out_red_out   = div_pix[0];
  assign out_green_out = div_pix[1];
  assign out_blue_out  = div_pix[2];

  `BFD_ASSERT_NOW(a_no_acc_settle, in_acc, !$past(cfg_we) && !$past(cfg_we, 2), "item accepted while geometry settles")
  `BFD_ASSERT_NOW(a_fw_live, fw_r, b_v_r && b_ctl_r.active, "forwarded sum without an active item")
  `BFD_ASSERT_NEXT(a_emit_hold, b_v_r && b_emit && !div_rdy, b_v_r && b_emit, "blocked block result dropped")

endmodule
